// ----- design/edi_pkg.sv -----
// shared constants and types for the euclidean distance / floor square root unit
`default_nettype none

package edi_pkg;

   localparam int FRACTION_BITS = 8;

   localparam int COORD_W  = 32;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int RAW_W    = 64;
   localparam int ROOT_W   = 32;
   localparam int ITER_W   = 5;

   localparam logic CMD_DISTANCE = 1'b0;
   localparam logic CMD_ROOT     = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MAG  = 7'b0000010,
      ST_SQX  = 7'b0000100,
      ST_SQY  = 7'b0001000,
      ST_SUM  = 7'b0010000,
      ST_ROOT = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// ----- design/euclidean_distance_isqrt_unit.sv -----
// floor square root of a raw word or of the squared distance between two fixed-point points
// one word at a time: a new request is accepted only in idle, after the result is loaded into the output register
// the root retires one bit-pair per cycle on a single 64-bit subtractor (32 steps);
// distance first passes through magnitude, two squarings on one 32x32 multiplier, and sum
// reset (synchronous, active high) returns to idle and drops rsp_valid
`default_nettype none

module euclidean_distance_isqrt_unit
   import edi_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_command,
   input  wire logic signed [COORD_W-1:0]  req_point_a_x,
   input  wire logic signed [COORD_W-1:0]  req_point_a_y,
   input  wire logic signed [COORD_W-1:0]  req_point_b_x,
   input  wire logic signed [COORD_W-1:0]  req_point_b_y,
   input  wire logic        [RAW_W-1:0]    req_raw_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic             [ROOT_W-1:0]   rsp_root_result
);

   state_type                state_ff, state_in;
   logic signed [DIFF_W-1:0] diff_x_ff, diff_x_in;
   logic signed [DIFF_W-1:0] diff_y_ff, diff_y_in;
   logic [COORD_W-1:0]       mag_x_ff, mag_x_in;
   logic [COORD_W-1:0]       mag_y_ff, mag_y_in;
   logic [RAW_W-1:0]         sq_ff, sq_in;
   logic [RAW_W-1:0]         acc_ff, acc_in;
   logic [RAW_W-1:0]         rem_ff, rem_in;
   logic [RAW_W-1:0]         res_ff, res_in;
   logic [RAW_W-1:0]         bit_ff, bit_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0]        rsp_root_ff, rsp_root_in;

   logic signed [DIFF_W-1:0] shift_x, shift_y;
   logic [COORD_W-1:0]       mul_op;
   logic [RAW_W-1:0]         mul_out;
   logic [RAW_W:0]           sum_wide;
   logic [RAW_W-1:0]         trial;
   logic [RAW_W:0]           trial_diff;
   logic                     accept, out_free;

   localparam logic [RAW_W-1:0] BIT_START = RAW_W'(1) << (RAW_W - 2);

   assign req_ready       = (state_ff == ST_IDLE);
   assign accept          = req_valid && req_ready;
   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root_result = rsp_root_ff;

   // floor by 2^fraction, then magnitude
   assign shift_x = diff_x_ff >>> FRACTION_BITS;
   assign shift_y = diff_y_ff >>> FRACTION_BITS;

   assign mul_op   = (state_ff == ST_SQX) ? mag_x_ff : mag_y_ff;
   assign mul_out  = RAW_W'(mul_op) * RAW_W'(mul_op);
   assign sum_wide = {1'b0, acc_ff} + {1'b0, sq_ff};

   // res and bit never overlap, so or is the sum
   assign trial      = res_ff | bit_ff;
   assign trial_diff = {1'b0, rem_ff} - {1'b0, trial};

   always_comb begin
      state_in     = state_ff;
      diff_x_in    = diff_x_ff;
      diff_y_in    = diff_y_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_root_in  = rsp_root_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               diff_x_in = DIFF_W'(req_point_a_x) - DIFF_W'(req_point_b_x);
               diff_y_in = DIFF_W'(req_point_a_y) - DIFF_W'(req_point_b_y);
               rem_in    = req_raw_value;
               res_in    = '0;
               bit_in    = BIT_START;
               iter_in   = '1;
               if (req_command == CMD_ROOT) begin
                  state_in = ST_ROOT;
               end else begin
                  state_in = ST_MAG;
               end
            end
         end
         ST_MAG: begin
            mag_x_in = shift_x[DIFF_W-1] ? COORD_W'(-shift_x) : COORD_W'(shift_x);
            mag_y_in = shift_y[DIFF_W-1] ? COORD_W'(-shift_y) : COORD_W'(shift_y);
            state_in = ST_SQX;
         end
         ST_SQX: begin
            sq_in    = mul_out;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            acc_in   = sq_ff;
            sq_in    = mul_out;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // saturate on carry out
            rem_in   = sum_wide[RAW_W] ? '1 : sum_wide[RAW_W-1:0];
            res_in   = '0;
            bit_in   = BIT_START;
            iter_in  = '1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (!trial_diff[RAW_W]) begin
               rem_in = trial_diff[RAW_W-1:0];
               res_in = (res_ff >> 1) | bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = res_ff[ROOT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      diff_x_ff   <= diff_x_in;
      diff_y_ff   <= diff_y_in;
      mag_x_ff    <= mag_x_in;
      mag_y_ff    <= mag_y_in;
      sq_ff       <= sq_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      iter_ff     <= iter_in;
      rsp_root_ff <= rsp_root_in;
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted word did not start work");

   a_probe_onehot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROOT |-> $onehot(bit_ff))
      else $error("root probe bit lost its single set bit");

   a_root_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && iter_ff == '0) |=> state_ff == ST_DONE)
      else $error("root did not finish after last bit pair");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished root not presented on output");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// self-checking testbench for the euclidean distance / floor square root unit
`default_nettype none

module testbench
   import edi_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic                      command;
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic        [RAW_W-1:0]   raw;
   } query_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_command = CMD_DISTANCE;
   logic signed [COORD_W-1:0] req_point_a_x = '0;
   logic signed [COORD_W-1:0] req_point_a_y = '0;
   logic signed [COORD_W-1:0] req_point_b_x = '0;
   logic signed [COORD_W-1:0] req_point_b_y = '0;
   logic        [RAW_W-1:0]   req_raw_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic        [ROOT_W-1:0]  rsp_root_result;

   query_type                 pending_queries[$];
   logic [ROOT_W-1:0]         expected_roots[$];
   query_type                 driven_query;
   int unsigned               sender_idle_pct = 0;
   int unsigned               receiver_stall_pct = 0;
   int unsigned               error_count = 0;

   euclidean_distance_isqrt_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_point_a_x   (req_point_a_x),
      .req_point_a_y   (req_point_a_y),
      .req_point_b_x   (req_point_b_x),
      .req_point_b_y   (req_point_b_y),
      .req_raw_value   (req_raw_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_root_result (rsp_root_result)
   );

   always #1 clock = ~clock;

   // bit-pair restoring floor square root
   function automatic logic [ROOT_W-1:0] isqrt64(input logic [RAW_W-1:0] operand);
      logic [RAW_W-1:0] remainder;
      logic [RAW_W-1:0] partial;
      logic [RAW_W-1:0] probe;
      remainder = operand;
      partial   = '0;
      probe     = 64'h4000_0000_0000_0000;
      while (probe > remainder)
         probe = probe >> 2;
      while (probe != 0) begin
         if (remainder >= partial + probe) begin
            remainder = remainder - (partial + probe);
            partial   = (partial >> 1) + probe;
         end else begin
            partial = partial >> 1;
         end
         probe = probe >> 2;
      end
      return partial[ROOT_W-1:0];
   endfunction

   // exact 33-bit difference, floored to whole pixels, then magnitude
   function automatic logic [RAW_W-1:0] pixel_delta(input logic signed [COORD_W-1:0] a,
                                                    input logic signed [COORD_W-1:0] b);
      logic signed [DIFF_W-1:0] diff;
      logic signed [DIFF_W-1:0] shifted;
      logic        [DIFF_W-1:0] magnitude;
      diff      = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
      shifted   = diff >>> FRACTION_BITS;
      magnitude = shifted[DIFF_W-1] ? -shifted : shifted;
      return RAW_W'(magnitude);
   endfunction

   function automatic logic [ROOT_W-1:0] predict_root(input query_type q);
      logic [RAW_W-1:0] dx;
      logic [RAW_W-1:0] dy;
      logic [RAW_W:0]   sq_sum;
      if (q.command == CMD_ROOT)
         return isqrt64(q.raw);
      dx     = pixel_delta(q.ax, q.bx);
      dy     = pixel_delta(q.ay, q.by);
      sq_sum = {1'b0, dx * dx} + {1'b0, dy * dy};
      // saturate when the squared sum overflows 64 bits
      if (sq_sum[RAW_W])
         sq_sum[RAW_W-1:0] = '1;
      return isqrt64(sq_sum[RAW_W-1:0]);
   endfunction

   task automatic add_query(input logic command, input logic [31:0] ax, input logic [31:0] ay,
                            input logic [31:0] bx, input logic [31:0] by,
                            input logic [63:0] raw);
      query_type q;
      q.command = command;
      q.ax      = ax;
      q.ay      = ay;
      q.bx      = bx;
      q.by      = by;
      q.raw     = raw;
      pending_queries.push_back(q);
   endtask

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_random_query();
      logic [31:0] ax;
      logic [31:0] ay;
      logic [31:0] bx;
      logic [31:0] by;
      logic [63:0] raw;
      logic [31:0] side;
      ax  = $urandom;
      ay  = $urandom;
      bx  = $urandom;
      by  = $urandom;
      raw = {$urandom, $urandom};
      if ($urandom_range(1) == 1) begin
         case ($urandom_range(3))
            1: raw = raw >> $urandom_range(63);
            2: begin
               // perfect squares and their neighbors
               side = $urandom;
               raw  = 64'(side) * 64'(side) + 64'($urandom_range(2)) - 64'd1;
            end
            3: raw = 64'($urandom_range(1000));
            default: ;
         endcase
         add_query(CMD_ROOT, ax, ay, bx, by, raw);
      end else begin
         case ($urandom_range(3))
            1: begin
               bx = ax + 32'($signed($urandom_range(4096)) - 2048);
               by = ay + 32'($signed($urandom_range(4096)) - 2048);
            end
            2: begin
               ax = pick_extreme();
               ay = pick_extreme();
               bx = pick_extreme();
               by = pick_extreme();
            end
            3: begin
               ax = 32'($signed(ax[19:0]));
               ay = 32'($signed(ay[19:0]));
               bx = 32'($signed(bx[19:0]));
               by = 32'($signed(by[19:0]));
            end
            default: ;
         endcase
         add_query(CMD_DISTANCE, ax, ay, bx, by, raw);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_roots.push_back(predict_root(driven_query));
         if (!req_valid || req_ready) begin
            if (pending_queries.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               driven_query  = pending_queries.pop_front();
               req_valid     <= 1'b1;
               req_command   <= driven_query.command;
               req_point_a_x <= driven_query.ax;
               req_point_a_y <= driven_query.ay;
               req_point_b_x <= driven_query.bx;
               req_point_b_y <= driven_query.by;
               req_raw_value <= driven_query.raw;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [ROOT_W-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_roots.size() == 0) begin
               $display("%0t: unexpected word, expected none, got root_result %0d",
                        $time, rsp_root_result);
               error_count++;
            end else begin
               want = expected_roots.pop_front();
               if (rsp_root_result !== want) begin
                  $display("%0t: root_result mismatch, expected %0d, got %0d",
                           $time, want, rsp_root_result);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   initial begin
      int unsigned idle_by_phase[4];
      int unsigned stall_by_phase[4];
      idle_by_phase  = '{0, 87, 0, 36};
      stall_by_phase = '{0, 0, 87, 36};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = idle_by_phase[phase];
         receiver_stall_pct = stall_by_phase[phase];
         if (phase == 0) begin
            // roots: small values, powers of four, top of range, alternating bits
            add_query(CMD_ROOT, $urandom, $urandom, $urandom, $urandom, 64'd0);
            add_query(CMD_ROOT, $urandom, $urandom, $urandom, $urandom, 64'd1);
            add_query(CMD_ROOT, $urandom, $urandom, $urandom, $urandom, 64'd2);
            add_query(CMD_ROOT, $urandom, $urandom, $urandom, $urandom, 64'd3);
            add_query(CMD_ROOT, $urandom, $urandom, $urandom, $urandom, 64'd4);
            add_query(CMD_ROOT, $urandom, $urandom, $urandom, $urandom, 64'd8);
            add_query(CMD_ROOT, $urandom, $urandom, $urandom, $urandom, 64'd9);
            add_query(CMD_ROOT, 0, 0, 0, 0, 64'h3FFF_FFFF_FFFF_FFFF);
            add_query(CMD_ROOT, 0, 0, 0, 0, 64'h4000_0000_0000_0000);
            add_query(CMD_ROOT, 0, 0, 0, 0, 64'h8000_0000_0000_0000);
            add_query(CMD_ROOT, '1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFF);
            add_query(CMD_ROOT, 0, 0, 0, 0, 64'hFFFF_FFFE_0000_0001);
            add_query(CMD_ROOT, 0, 0, 0, 0, 64'hFFFF_FFFE_0000_0000);
            add_query(CMD_ROOT, 0, 0, 0, 0, 64'h5555_5555_5555_5555);
            add_query(CMD_ROOT, 0, 0, 0, 0, 64'hAAAA_AAAA_AAAA_AAAA);
            // distances: coincident points, widest spans both ways, rounding of small deltas
            add_query(CMD_DISTANCE, 0, 0, 0, 0, {$urandom, $urandom});
            add_query(CMD_DISTANCE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, '1);
            add_query(CMD_DISTANCE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 0);
            add_query(CMD_DISTANCE, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 0);
            add_query(CMD_DISTANCE, 0, 0, 1, 0, 0);
            add_query(CMD_DISTANCE, 255, 0, 0, 0, 0);
            add_query(CMD_DISTANCE, 0, 0, 256, 256, 0);
            add_query(CMD_DISTANCE, 256, -256, 0, 0, 0);
            add_query(CMD_DISTANCE, 3 << FRACTION_BITS, 0, 0, 4 << FRACTION_BITS, 0);
         end
         repeat (188) add_random_query();
         while (pending_queries.size() != 0 || req_valid || expected_roots.size() != 0)
            @(posedge clock);
      end
      // let any stray word show up
      repeat (60) @(posedge clock);
      if (error_count == 0)
         $display("euclidean_distance_isqrt_unit test passed");
      else
         $display("euclidean_distance_isqrt_unit test failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("euclidean_distance_isqrt_unit test failed");
      $finish;
   end

endmodule

`default_nettype wire
